// File: sv/u8d_pkg.sv
// shared types, constants and byte classification for the strict utf-8 decoder
package u8d_pkg;

    localparam logic [7:0]  BYTE_ASCII_LIM = 8'h80;
    localparam logic [7:0]  CONT_MASK      = 8'hC0;
    localparam logic [7:0]  CONT_TAG       = 8'h80;
    localparam logic [7:0]  LEAD2_LO       = 8'hC2;
    localparam logic [7:0]  LEAD2_HI       = 8'hDF;
    localparam logic [7:0]  LEAD3_LO       = 8'hE0;
    localparam logic [7:0]  LEAD3_HI       = 8'hEF;
    localparam logic [7:0]  LEAD4_LO       = 8'hF0;
    localparam logic [7:0]  LEAD4_HI       = 8'hF4;
    localparam logic [7:0]  LEAD_E0        = 8'hE0;
    localparam logic [7:0]  LEAD_ED        = 8'hED;
    localparam logic [7:0]  LEAD_F0        = 8'hF0;
    localparam logic [7:0]  LEAD_F4        = 8'hF4;
    localparam logic [7:0]  CONT_A0        = 8'hA0;
    localparam logic [7:0]  CONT_90        = 8'h90;
    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    typedef enum logic [2:0] {
        ACT_STORE,
        ACT_CHAR,
        ACT_REP,
        ACT_END,
        ACT_FLUSH_EOT,
        ACT_FLUSH_BAD
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_TAIL
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic sel_held;
        logic apply;
        logic start_flush;
        logic emit_rep;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic slot_free;
        logic rep_last;
        logic flush_eot;
    } sts_t;

    // total sequence length for a lead byte, 0 when not a valid lead
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b inside {[LEAD2_LO:LEAD2_HI]})
        begin
            n = 3'd2;
        end
        else if (b inside {[LEAD3_LO:LEAD3_HI]})
        begin
            n = 3'd3;
        end
        else if (b inside {[LEAD4_LO:LEAD4_HI]})
        begin
            n = 3'd4;
        end
        return n;
    endfunction

    // whether b may follow the lead at position pos
    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic ok;
        ok = ((b & CONT_MASK) == CONT_TAG);
        if (pos == 2'd1)
        begin
            if (lead == LEAD_E0 && b < CONT_A0)
            begin
                ok = 1'b0;
            end
            if (lead == LEAD_ED && b >= CONT_A0)
            begin
                ok = 1'b0;
            end
            if (lead == LEAD_F0 && b < CONT_90)
            begin
                ok = 1'b0;
            end
            if (lead == LEAD_F4 && b >= CONT_90)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// File: sv/u8d_if.sv
// handshake channels for text bytes and decoded characters
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface u8d_char_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  byte_length;
    logic        replaced;
    logic        end_of_text;
    logic        no_character;

    modport source (output valid, output code_point, output byte_length, output replaced,
                    output end_of_text, output no_character, input ready);
    modport sink (input valid, input code_point, input byte_length, input replaced,
                  input end_of_text, input no_character, output ready);
endinterface

// File: sv/u8d_datapath.sv
// pending store, classification, replacement counter and output register
module u8d_datapath
    import u8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  text_byte,
    input  cmd_t        cmd,
    output sts_t        sts,
    u8d_char_if.source  chars
);

    logic [7:0]  pend_reg [3];
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [7:0]  held_reg;
    logic [1:0]  rep_reg;
    logic [1:0]  rep_next;
    logic        eot_mode_reg;
    logic        eot_mode_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [20:0] cp_reg;
    logic [2:0]  len_reg;
    logic        rep_flag_reg;
    logic        eot_reg;
    logic        nochar_reg;

    logic [7:0]  cur_byte;
    logic [2:0]  need;
    logic [2:0]  cnt_ext;
    act_t        act;
    logic [20:0] char_cp;
    logic [2:0]  char_len;
    logic        slot_free;
    logic        do_write;

    assign cur_byte  = cmd.sel_held ? held_reg : text_byte;
    assign need      = seq_len(pend_reg[0]);
    assign cnt_ext   = {1'b0, cnt_reg};
    assign slot_free = !out_valid_reg || chars.ready;

    // classify the current byte against the pending sequence
    always_comb
    begin
        act = ACT_REP;
        if (cur_byte == 8'd0)
        begin
            act = (cnt_reg == 2'd0) ? ACT_END : ACT_FLUSH_EOT;
        end
        else if (cnt_reg != 2'd0)
        begin
            if (need > cnt_ext && cont_ok(pend_reg[0], cnt_reg, cur_byte))
            begin
                act = (cnt_ext + 3'd1 == need) ? ACT_CHAR : ACT_STORE;
            end
            else
            begin
                act = ACT_FLUSH_BAD;
            end
        end
        else if (cur_byte < BYTE_ASCII_LIM)
        begin
            act = ACT_CHAR;
        end
        else if (seq_len(cur_byte) != 3'd0)
        begin
            act = ACT_STORE;
        end
    end

    // code point of a completed character
    always_comb
    begin
        char_cp  = {13'd0, cur_byte};
        char_len = 3'd1;
        if (cnt_reg != 2'd0)
        begin
            char_len = need;
            case (need)
                3'd2:
                begin
                    char_cp = {10'd0, pend_reg[0][4:0], cur_byte[5:0]};
                end
                3'd3:
                begin
                    char_cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], cur_byte[5:0]};
                end
                3'd4:
                begin
                    char_cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                               cur_byte[5:0]};
                end
                default:
                begin
                    char_cp = {13'd0, cur_byte};
                end
            endcase
        end
    end

    assign do_write = cmd.emit_rep ||
                      (cmd.apply && (act == ACT_CHAR || act == ACT_REP || act == ACT_END));

    always_comb
    begin
        cnt_next       = cnt_reg;
        rep_next       = rep_reg;
        eot_mode_next  = eot_mode_reg;
        out_valid_next = out_valid_reg;
        if (do_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (chars.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.start_flush)
        begin
            rep_next      = cnt_reg;
            eot_mode_next = (act == ACT_FLUSH_EOT);
        end
        else if (cmd.emit_rep)
        begin
            rep_next = rep_reg - 2'd1;
            if (rep_reg == 2'd1)
            begin
                cnt_next = 2'd0;
            end
        end
        else if (cmd.apply)
        begin
            if (act == ACT_STORE)
            begin
                cnt_next = cnt_reg + 2'd1;
            end
            else if (act == ACT_CHAR)
            begin
                cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 2'd0;
            rep_reg       <= 2'd0;
            eot_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rep_reg       <= rep_next;
            eot_mode_reg  <= eot_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            held_reg <= text_byte;
        end
        if (cmd.apply && act == ACT_STORE)
        begin
            pend_reg[cnt_reg] <= cur_byte;
        end
        if (cmd.emit_rep)
        begin
            cp_reg       <= REPLACEMENT_CP;
            len_reg      <= 3'd1;
            rep_flag_reg <= 1'b1;
            eot_reg      <= eot_mode_reg && (rep_reg == 2'd1);
            nochar_reg   <= 1'b0;
        end
        else if (do_write)
        begin
            case (act)
                ACT_CHAR:
                begin
                    cp_reg       <= char_cp;
                    len_reg      <= char_len;
                    rep_flag_reg <= 1'b0;
                    eot_reg      <= 1'b0;
                    nochar_reg   <= 1'b0;
                end
                ACT_END:
                begin
                    cp_reg       <= 21'd0;
                    len_reg      <= 3'd0;
                    rep_flag_reg <= 1'b0;
                    eot_reg      <= 1'b1;
                    nochar_reg   <= 1'b1;
                end
                default:
                begin
                    cp_reg       <= REPLACEMENT_CP;
                    len_reg      <= 3'd1;
                    rep_flag_reg <= 1'b1;
                    eot_reg      <= 1'b0;
                    nochar_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign sts.act       = act;
    assign sts.slot_free = slot_free;
    assign sts.rep_last  = (rep_reg == 2'd1);
    assign sts.flush_eot = eot_mode_reg;

    assign chars.valid        = out_valid_reg;
    assign chars.code_point   = cp_reg;
    assign chars.byte_length  = len_reg;
    assign chars.replaced     = rep_flag_reg;
    assign chars.end_of_text  = eot_reg;
    assign chars.no_character = nochar_reg;

    a_nochar_eot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && nochar_reg |-> eot_reg)
        else $error("no-character word without end of text");

    a_full_pending_is_4byte: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd3 |-> need == 3'd4)
        else $error("three bytes pending for a short sequence");

    a_emit_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_rep |-> rep_reg != 2'd0 && slot_free)
        else $error("replacement emitted with empty flush count");

    a_write_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |-> slot_free)
        else $error("output word overwritten");

endmodule

// File: sv/u8d_ctrl.sv
// controller state machine sequencing accept, flush and rescan
module u8d_ctrl
    import u8d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = (state_reg == ST_IDLE) && in_valid && sts.slot_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (sts.act == ACT_FLUSH_EOT || sts.act == ACT_FLUSH_BAD))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (sts.slot_free && sts.rep_last)
                begin
                    state_next = sts.flush_eot ? ST_IDLE : ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (sts.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = sts.slot_free;
                cmd.load_byte = accept;
                if (accept)
                begin
                    if (sts.act == ACT_FLUSH_EOT || sts.act == ACT_FLUSH_BAD)
                    begin
                        cmd.start_flush = 1'b1;
                    end
                    else
                    begin
                        cmd.apply = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.emit_rep = sts.slot_free;
            end
            ST_TAIL:
            begin
                cmd.sel_held = 1'b1;
                cmd.apply    = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_flush_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("input taken during flush or rescan");

    a_tail_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TAIL |-> $past(state_reg) == ST_FLUSH || $past(state_reg) == ST_TAIL)
        else $error("rescan entered without flush");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.apply, cmd.start_flush, cmd.emit_rep}))
        else $error("conflicting datapath commands");

endmodule

// File: sv/utf8_strict_decoder.sv
// strict utf-8 decoder top level
// a result word is registered and shows in the cycle after the byte that completes it
// one byte per cycle while the output slot is free; with n bytes pending, a broken
//   sequence stalls input for n replacement words and a rescan of the held byte, and a
//   terminator stalls it for n replacement words, the last marked end of text
// reset: asynchronous active low, clears pending count, flush state and output valid
module utf8_strict_decoder
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    u8d_byte_if.sink   text,
    u8d_char_if.source chars
);

    cmd_t cmd;
    sts_t sts;

    u8d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_ready (text.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    u8d_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (text.text_byte),
        .cmd       (cmd),
        .sts       (sts),
        .chars     (chars)
    );

endmodule
